// ----- rtl/lissajous_point_generator_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Lissajous point generator checks.
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef LISSAJOUS_POINT_GENERATOR_UNIT_MACROS_SVH
`define LISSAJOUS_POINT_GENERATOR_UNIT_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that sig holds its value while the output item is stalled.
`define LPG_ASSERT_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && !out_ready) |=> (out_valid && $stable(sig))) \
        else $error(msg);

`endif

// ----- rtl/lpg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpg_pkg
// Shared types, constants and the sine table entry function for the
// Lissajous point generator.
// ---------------------------------------------------------------------------
package lpg_pkg;

    // Default parameter values
    localparam int DEF_POINT_LIMIT    = 64;
    localparam int DEF_SINE_ADDR_BITS = 10;

    // Field widths
    localparam int DATA_W  = 16;
    localparam int POS_W   = 17;
    localparam int MAG_W   = 15;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd4;

    // Configuration reset values
    localparam logic [DATA_W-1:0]  RST_TIME_STEP   = 16'd655;
    localparam logic [DATA_W-1:0]  RST_PHASE       = 16'd0;
    localparam logic [COUNT_W-1:0] RST_POINT_COUNT = 7'd64;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  inc_en;
        axis_t inc_axis;
        logic  issue;
    } lpg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic issue_last;
        logic adv;
    } lpg_sts_t;

    // Quarter-wave sine entry k of a 2^abits table, Q0.15 magnitude
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(2 * k + 1) * HALF_PI_Q30) >> (abits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/lissajous_point_generator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lissajous_point_generator_unit
// 3-D Lissajous curve generator: one request in, up to POINT_LIMIT points out.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   request  | in_valid/in_ready   | amp_x..amp_z, freq_x..freq_z
//   point    | out_valid/out_ready | pos_x..pos_z, point_index, last_point
//   config   | cfg_we              | cfg_index, cfg_data
//
// A request takes the accept cycle, a setup step per axis in which one
// shared 16x16 multiplier forms the per-axis phase step, then one point per
// cycle while the output is not stalled. Points pass the lookup register and
// the output register, then follow each cycle while out_ready is high.
// A stalled output freezes the point pipeline. Reset clears the handshake
// state and loads the register defaults; the sine ROM is constant.
// ---------------------------------------------------------------------------
module lissajous_point_generator_unit #(
    parameter int POINT_LIMIT    = lpg_pkg::DEF_POINT_LIMIT,
    parameter int SINE_ADDR_BITS = lpg_pkg::DEF_SINE_ADDR_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpg_pkg::DATA_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lpg_pkg::DATA_W-1:0]       amp_x,
    input  logic [lpg_pkg::DATA_W-1:0]       amp_y,
    input  logic [lpg_pkg::DATA_W-1:0]       amp_z,
    input  logic [lpg_pkg::DATA_W-1:0]       freq_x,
    input  logic [lpg_pkg::DATA_W-1:0]       freq_y,
    input  logic [lpg_pkg::DATA_W-1:0]       freq_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [lpg_pkg::POS_W-1:0] pos_x,
    output logic signed [lpg_pkg::POS_W-1:0] pos_y,
    output logic signed [lpg_pkg::POS_W-1:0] pos_z,
    output logic [lpg_pkg::IDX_W-1:0]        point_index,
    output logic                             last_point
);

    lpg_pkg::lpg_cmd_t cmd;
    lpg_pkg::lpg_sts_t sts;

    // Sequence requests
    lpg_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Compute points
    lpg_datapath #(
        .POINT_LIMIT    (POINT_LIMIT),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .amp_x       (amp_x),
        .amp_y       (amp_y),
        .amp_z       (amp_z),
        .freq_x      (freq_x),
        .freq_y      (freq_y),
        .freq_z      (freq_z),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_index (point_index),
        .last_point  (last_point)
    );

endmodule

// ----- rtl/lpg_controller.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpg_controller
// Request sequencer: accepts a request, steps the axis increment setup if
// points are owed, then issues points until the datapath flags the last one.
// ---------------------------------------------------------------------------
module lpg_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpg_pkg::lpg_sts_t sts,
    output lpg_pkg::lpg_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    lpg_pkg::axis_t axis_reg;
    lpg_pkg::axis_t axis_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.inc_axis = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!sts.count_zero)
                    begin
                        state_next = ST_SETUP;
                        axis_next  = lpg_pkg::AXIS_X;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.inc_en = 1'b1;
                if (axis_reg == lpg_pkg::AXIS_Z)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    axis_next = lpg_pkg::axis_t'(axis_reg + 2'd1);
                end
            end
            ST_RUN:
            begin
                if (sts.adv)
                begin
                    cmd.issue = 1'b1;
                    if (sts.issue_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= lpg_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// ----- rtl/lpg_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpg_datapath
// Config registers, phase accumulators, shared increment multiplier, sine
// ROM lookup stage and amplitude scaling into the output register.
// ---------------------------------------------------------------------------
module lpg_datapath #(
    parameter int POINT_LIMIT    = lpg_pkg::DEF_POINT_LIMIT,
    parameter int SINE_ADDR_BITS = lpg_pkg::DEF_SINE_ADDR_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpg_pkg::DATA_W-1:0]           cfg_data,
    input  logic [lpg_pkg::DATA_W-1:0]           amp_x,
    input  logic [lpg_pkg::DATA_W-1:0]           amp_y,
    input  logic [lpg_pkg::DATA_W-1:0]           amp_z,
    input  logic [lpg_pkg::DATA_W-1:0]           freq_x,
    input  logic [lpg_pkg::DATA_W-1:0]           freq_y,
    input  logic [lpg_pkg::DATA_W-1:0]           freq_z,
    input  lpg_pkg::lpg_cmd_t                    cmd,
    output lpg_pkg::lpg_sts_t                    sts,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lpg_pkg::POS_W-1:0]     pos_x,
    output logic signed [lpg_pkg::POS_W-1:0]     pos_y,
    output logic signed [lpg_pkg::POS_W-1:0]     pos_z,
    output logic [lpg_pkg::IDX_W-1:0]            point_index,
    output logic                                 last_point
);

    localparam int TBL     = 1 << SINE_ADDR_BITS;
    localparam int CNT_W   = $clog2(POINT_LIMIT + 1);
    localparam int DATA_W  = lpg_pkg::DATA_W;
    localparam int MAG_W   = lpg_pkg::MAG_W;
    localparam int POS_W   = lpg_pkg::POS_W;
    localparam int IDX_W   = lpg_pkg::IDX_W;
    localparam int COUNT_W = lpg_pkg::COUNT_W;
    localparam int PROD_W  = DATA_W + MAG_W + 1;

    typedef logic [MAG_W-1:0] rom_t [TBL];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < TBL; k++)
        begin
            r[k] = lpg_pkg::sine_entry(k, SINE_ADDR_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers
    logic [DATA_W-1:0]  time_step_reg;
    logic [DATA_W-1:0]  phase_off_reg [3];
    logic [COUNT_W-1:0] point_count_reg;

    // Request registers
    logic [DATA_W-1:0] amp_reg  [3];
    logic [DATA_W-1:0] freq_reg [3];
    logic [DATA_W-1:0] inc_reg  [3];
    logic [DATA_W-1:0] ph_reg   [3];
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Lookup stage
    logic              s1_valid_reg;
    logic [MAG_W-1:0]  s1_mag_reg [3];
    logic              s1_neg_reg [3];
    logic [DATA_W-1:0] s1_amp_reg [3];
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_last_reg;

    // Output stage
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_pos_reg [3];
    logic [IDX_W-1:0]        out_idx_reg;
    logic                    out_last_reg;

    logic [DATA_W-1:0]         amp_in [3];
    logic [DATA_W-1:0]         freq_in [3];
    logic [DATA_W-1:0]         freq_sel;
    logic [2*DATA_W-1:0]       inc_prod;
    logic [SINE_ADDR_BITS-1:0] rom_addr [3];
    logic [PROD_W-1:0]         scale_prod [3];
    logic [POS_W-1:0]          scale_mag [3];
    logic signed [POS_W-1:0]   scale_pos [3];
    logic [CNT_W-1:0]          count_next;
    logic                      adv;
    logic                      issue_last;

    assign amp_in[0]  = amp_x;
    assign amp_in[1]  = amp_y;
    assign amp_in[2]  = amp_z;
    assign freq_in[0] = freq_x;
    assign freq_in[1] = freq_y;
    assign freq_in[2] = freq_z;

    // Clamp the point count to the limit
    always_comb
    begin
        if (point_count_reg > COUNT_W'(POINT_LIMIT))
        begin
            count_next = CNT_W'(POINT_LIMIT);
        end
        else
        begin
            count_next = CNT_W'(point_count_reg);
        end
    end

    assign adv        = !out_valid_reg || out_ready;
    assign issue_last = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == COUNT_W'(count_reg));

    assign sts.count_zero = (point_count_reg == '0);
    assign sts.issue_last = issue_last;
    assign sts.adv        = adv;

    // Select the axis for the shared increment multiplier
    always_comb
    begin
        case (cmd.inc_axis)
            lpg_pkg::AXIS_X: freq_sel = freq_reg[0];
            lpg_pkg::AXIS_Y: freq_sel = freq_reg[1];
            lpg_pkg::AXIS_Z: freq_sel = freq_reg[2];
            default:         freq_sel = freq_reg[0];
        endcase
    end

    assign inc_prod = freq_sel * time_step_reg;

    // Fold the phase into a quarter-wave address, then scale the magnitude
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rom_addr[a] = ph_reg[a][13 -: SINE_ADDR_BITS];
            if (ph_reg[a][14])
            begin
                rom_addr[a] = ~ph_reg[a][13 -: SINE_ADDR_BITS];
            end
            scale_prod[a] = PROD_W'(s1_amp_reg[a]) * PROD_W'(s1_mag_reg[a])
                          + PROD_W'(1 << 14);
            scale_mag[a]  = scale_prod[a][15 +: POS_W];
            if (s1_neg_reg[a])
            begin
                scale_pos[a] = signed'(-scale_mag[a]);
            end
            else
            begin
                scale_pos[a] = signed'(scale_mag[a]);
            end
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= lpg_pkg::RST_TIME_STEP;
            phase_off_reg[0] <= lpg_pkg::RST_PHASE;
            phase_off_reg[1] <= lpg_pkg::RST_PHASE;
            phase_off_reg[2] <= lpg_pkg::RST_PHASE;
            point_count_reg  <= lpg_pkg::RST_POINT_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpg_pkg::CFG_TIME_STEP:   time_step_reg    <= cfg_data;
                lpg_pkg::CFG_PHASE_X:     phase_off_reg[0] <= cfg_data;
                lpg_pkg::CFG_PHASE_Y:     phase_off_reg[1] <= cfg_data;
                lpg_pkg::CFG_PHASE_Z:     phase_off_reg[2] <= cfg_data;
                lpg_pkg::CFG_POINT_COUNT: point_count_reg  <= cfg_data[COUNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Capture the request, set up increments, advance phases
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg <= count_next;
            idx_reg   <= '0;
            for (int a = 0; a < 3; a++)
            begin
                amp_reg[a]  <= amp_in[a];
                freq_reg[a] <= freq_in[a];
                ph_reg[a]   <= phase_off_reg[a];
            end
        end
        if (cmd.inc_en)
        begin
            case (cmd.inc_axis)
                lpg_pkg::AXIS_X: inc_reg[0] <= inc_prod[12 +: DATA_W];
                lpg_pkg::AXIS_Y: inc_reg[1] <= inc_prod[12 +: DATA_W];
                lpg_pkg::AXIS_Z: inc_reg[2] <= inc_prod[12 +: DATA_W];
                default:         ;
            endcase
        end
        if (cmd.issue)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            for (int a = 0; a < 3; a++)
            begin
                ph_reg[a] <= ph_reg[a] + inc_reg[a];
            end
        end
    end

    // Look up the sine for the issued point
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_idx_reg  <= idx_reg;
            s1_last_reg <= issue_last;
            for (int a = 0; a < 3; a++)
            begin
                s1_mag_reg[a] <= SINE_ROM[rom_addr[a]];
                s1_neg_reg[a] <= ph_reg[a][15];
                s1_amp_reg[a] <= amp_reg[a];
            end
        end
    end

    // Move the looked-up point into the output register
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_idx_reg  <= s1_idx_reg;
            out_last_reg <= s1_last_reg;
            for (int a = 0; a < 3; a++)
            begin
                out_pos_reg[a] <= scale_pos[a];
            end
        end
    end

    // Advance stage valids when the output is free or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= cmd.issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = out_pos_reg[0];
    assign pos_y       = out_pos_reg[1];
    assign pos_z       = out_pos_reg[2];
    assign point_index = out_idx_reg;
    assign last_point  = out_last_reg;

endmodule

// ----- rtl/lpg_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpg_checker
// Port-level checks on point ordering and output stalls, bound to the top.
// ---------------------------------------------------------------------------
`include "lissajous_point_generator_unit_macros.svh"

module lpg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [lpg_pkg::POS_W-1:0] pos_x,
    input logic [lpg_pkg::IDX_W-1:0]        point_index,
    input logic                             last_point
);

    // Stalled point holds
    `LPG_ASSERT_HOLD(a_hold_pos, pos_x, "stalled point changed")

    // Points of one request come without gaps
    `LPG_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last_point, out_valid, "gap within a curve")

    // Indexes count up by one within a request
    `LPG_ASSERT_NEXT(a_index_step, out_valid && out_ready && !last_point, point_index == lpg_pkg::IDX_W'($past(point_index) + 6'd1), "point index skipped")

    // A new curve starts at index zero
    `LPG_ASSERT_NEXT(a_index_restart, out_valid && out_ready && last_point, !out_valid || point_index == '0, "curve did not restart at zero")

endmodule

bind lissajous_point_generator_unit lpg_checker u_lpg_checker (.*);

// ----- tb/lissajous_point_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lissajous_point_checker
// Watches the register port and both item channels of the Lissajous point
// generator, works out the points every accepted request must produce and
// compares each accepted output point with the oldest one still owed.
// ---------------------------------------------------------------------------
module lissajous_point_checker
    import lpg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [DATA_W-1:0]           amp_x,
    input  logic [DATA_W-1:0]           amp_y,
    input  logic [DATA_W-1:0]           amp_z,
    input  logic [DATA_W-1:0]           freq_x,
    input  logic [DATA_W-1:0]           freq_y,
    input  logic [DATA_W-1:0]           freq_z,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic [IDX_W-1:0]            point_index,
    input  logic                        last_point,
    output int                          mismatch_count,
    output int                          pending_points,
    output int                          points_checked
);

    localparam int PT_LIMIT   = DEF_POINT_LIMIT;
    localparam int ABITS      = DEF_SINE_ADDR_BITS;
    localparam int ROM_DEPTH  = 1 << ABITS;
    localparam int REPORT_MAX = 10;
    localparam int TAYLOR_N   = 8;
    localparam longint unsigned Q15_MAX = 64'd32767;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [IDX_W-1:0]        idx;
        logic                    last;
    } point_t;

    logic [MAG_W-1:0]   quarter_sine [ROM_DEPTH];
    logic [DATA_W-1:0]  step_reg;
    logic [DATA_W-1:0]  phx_reg;
    logic [DATA_W-1:0]  phy_reg;
    logic [DATA_W-1:0]  phz_reg;
    logic [COUNT_W-1:0] count_reg;
    point_t             curve_points_q [$];
    point_t             want;
    point_t             got;

    // Q0.15 magnitude of table entry k: odd-multiple sample of a quarter wave
    function automatic logic [MAG_W-1:0] taylor_sine(input int unsigned k);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint unsigned mag;
        longint signed   acc;
        int              n;
        angle    = (longint'(2 * k + 1) * HALF_PI_Q30) >> (ABITS + 1);
        angle_sq = (angle * angle) >> 30;
        term     = angle;
        acc      = longint'(angle);
        for (n = 1; n <= TAYLOR_N; n++)
        begin
            term = (term * angle_sq) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        mag = (longint'(acc) * Q15_MAX + (64'd1 << 29)) >> 30;
        if (mag > Q15_MAX)
            mag = Q15_MAX;
        return mag[MAG_W-1:0];
    endfunction

    // Signed sine of a 1/65536-turn phase through the quarter-wave table
    function automatic int signed_sine(input logic [DATA_W-1:0] phase);
        logic [1:0]       quad;
        logic [ABITS-1:0] addr;
        int               mag;
        quad = phase[15:14];
        addr = phase[13 -: ABITS];
        if (quad[0])
            addr = ABITS'(ROM_DEPTH - 1) - addr;
        mag = int'(quarter_sine[addr]);
        return quad[1] ? -mag : mag;
    endfunction

    // Amplitude times sine, magnitude rounded half up, sign reapplied
    function automatic logic signed [POS_W-1:0] scaled_axis(input logic [DATA_W-1:0] amp,
                                                            input logic [DATA_W-1:0] phase);
        int               s;
        longint unsigned  m;
        logic [POS_W-1:0] r;
        s = signed_sine(phase);
        m = (longint'(amp) * longint'(s < 0 ? -s : s) + (64'd1 << 14)) >> 15;
        r = m[POS_W-1:0];
        if (s < 0)
            r = -r;
        return signed'(r);
    endfunction

    // Append every point one request owes, using the current register copy
    task automatic queue_curve_points(input logic [DATA_W-1:0] ax, input logic [DATA_W-1:0] ay,
                                      input logic [DATA_W-1:0] az, input logic [DATA_W-1:0] fx,
                                      input logic [DATA_W-1:0] fy, input logic [DATA_W-1:0] fz);
        logic [DATA_W-1:0] inc_x;
        logic [DATA_W-1:0] inc_y;
        logic [DATA_W-1:0] inc_z;
        logic [DATA_W-1:0] ph_x;
        logic [DATA_W-1:0] ph_y;
        logic [DATA_W-1:0] ph_z;
        logic [31:0]       prod;
        int                count;
        int                i;
        point_t            p;
        prod  = {16'b0, fx} * {16'b0, step_reg};
        inc_x = prod[27:12];
        prod  = {16'b0, fy} * {16'b0, step_reg};
        inc_y = prod[27:12];
        prod  = {16'b0, fz} * {16'b0, step_reg};
        inc_z = prod[27:12];
        ph_x  = phx_reg;
        ph_y  = phy_reg;
        ph_z  = phz_reg;
        count = (int'(count_reg) > PT_LIMIT) ? PT_LIMIT : int'(count_reg);
        for (i = 0; i < count; i++)
        begin
            p.x    = scaled_axis(ax, ph_x);
            p.y    = scaled_axis(ay, ph_y);
            p.z    = scaled_axis(az, ph_z);
            p.idx  = IDX_W'(i);
            p.last = (i == count - 1);
            curve_points_q.push_back(p);
            ph_x = ph_x + inc_x;
            ph_y = ph_y + inc_y;
            ph_z = ph_z + inc_z;
        end
    endtask

    // Build the sine table once
    initial
    begin
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            quarter_sine[k] = taylor_sine(k);
        end
    end

    // Compare output items, predict on input items, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       = RST_TIME_STEP;
            phx_reg        = RST_PHASE;
            phy_reg        = RST_PHASE;
            phz_reg        = RST_PHASE;
            count_reg      = RST_POINT_COUNT;
            curve_points_q.delete();
            mismatch_count = 0;
            pending_points = 0;
            points_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.x    = pos_x;
                got.y    = pos_y;
                got.z    = pos_z;
                got.idx  = point_index;
                got.last = last_point;
                if (curve_points_q.size() == 0)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("[%0t] unexpected point: x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                 $realtime, got.x, got.y, got.z, got.idx, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = curve_points_q.pop_front();
                    points_checked++;
                    if (got !== want)
                    begin
                        if (mismatch_count < REPORT_MAX)
                        begin
                            $display("[%0t] point mismatch, expected x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                     $realtime, want.x, want.y, want.z, want.idx, want.last);
                            $display("[%0t]                   got x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                     $realtime, got.x, got.y, got.z, got.idx, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                queue_curve_points(amp_x, amp_y, amp_z, freq_x, freq_y, freq_z);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:   step_reg  = cfg_data;
                    CFG_PHASE_X:     phx_reg   = cfg_data;
                    CFG_PHASE_Y:     phy_reg   = cfg_data;
                    CFG_PHASE_Z:     phz_reg   = cfg_data;
                    CFG_POINT_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end

            pending_points = curve_points_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives curve requests and register settings into the Lissajous point
// generator under changing idle and stall patterns, including a long output
// hold-off; the point checker beside the block judges every output item.
// ---------------------------------------------------------------------------
module tb_top;
    import lpg_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_CYCLES    = 96;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 25;
    localparam int PRESSURE_PHASE  = 3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int BUSY_PCT        = 82;
    localparam int LIGHT_PCT       = 26;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]       cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [DATA_W-1:0]       amp_x;
    logic [DATA_W-1:0]       amp_y;
    logic [DATA_W-1:0]       amp_z;
    logic [DATA_W-1:0]       freq_x;
    logic [DATA_W-1:0]       freq_y;
    logic [DATA_W-1:0]       freq_z;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        point_index;
    logic                    last_point;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;
    int requests_sent;
    int settings_used;
    int mismatch_count;
    int pending_points;
    int points_checked;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lissajous_point_generator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .amp_x       (amp_x),
        .amp_y       (amp_y),
        .amp_z       (amp_z),
        .freq_x      (freq_x),
        .freq_y      (freq_y),
        .freq_z      (freq_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_index (point_index),
        .last_point  (last_point)
    );

    lissajous_point_checker point_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .amp_x          (amp_x),
        .amp_y          (amp_y),
        .amp_z          (amp_z),
        .freq_x         (freq_x),
        .freq_y         (freq_y),
        .freq_z         (freq_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .point_index    (point_index),
        .last_point     (last_point),
        .mismatch_count (mismatch_count),
        .pending_points (pending_points),
        .points_checked (points_checked)
    );

    // Receiver: honor a pending hold-off first, else stall at random
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles  = hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stop a run that hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d points still owed", cycle_count, pending_points);
        $display("end of test: mismatches");
        $finish;
    end

    // Mostly random words, with the two extremes now and then
    function automatic logic [DATA_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DATA_W'($urandom);
    endfunction

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = BUSY_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = BUSY_PCT;
            end
            default:
            begin
                send_idle_pct  = LIGHT_PCT;
                recv_stall_pct = LIGHT_PCT;
            end
        endcase
    endtask

    // Offer one request and hold it until accepted; enter and leave at negedge
    task automatic offer_request(input logic [DATA_W-1:0] ax, input logic [DATA_W-1:0] ay,
                                 input logic [DATA_W-1:0] az, input logic [DATA_W-1:0] fx,
                                 input logic [DATA_W-1:0] fy, input logic [DATA_W-1:0] fz);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        amp_x    <= ax;
        amp_y    <= ay;
        amp_z    <= az;
        freq_x   <= fx;
        freq_y   <= fy;
        freq_z   <= fz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic offer_random_request();
        offer_request(pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), pick_word());
    endtask

    // Drop valid once a burst is over
    task automatic close_burst();
        in_valid <= 1'b0;
    endtask

    // Wait for every owed point, then let any pointless request finish
    task automatic drain();
        while (pending_points != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic reg_release();
        cfg_we <= 1'b0;
    endtask

    // Write all five registers; count goes in as a full data word
    task automatic apply_setting(input logic [DATA_W-1:0] ts, input logic [DATA_W-1:0] px,
                                 input logic [DATA_W-1:0] py, input logic [DATA_W-1:0] pz,
                                 input logic [DATA_W-1:0] cnt);
        reg_write(CFG_TIME_STEP, ts);
        reg_write(CFG_PHASE_X, px);
        reg_write(CFG_PHASE_Y, py);
        reg_write(CFG_PHASE_Z, pz);
        reg_write(CFG_POINT_COUNT, cnt);
        reg_release();
        settings_used++;
    endtask

    // Random setting: mostly short curves, sometimes none, full or clamped
    task automatic apply_random_setting();
        logic [DATA_W-1:0] cnt;
        cnt = DATA_W'($urandom);
        case ($urandom_range(0, 9))
            0:       cnt[COUNT_W-1:0] = '0;
            1:       cnt[COUNT_W-1:0] = COUNT_W'(DEF_POINT_LIMIT);
            2:       cnt[COUNT_W-1:0] = COUNT_W'($urandom_range(DEF_POINT_LIMIT + 1, 127));
            3:       cnt[COUNT_W-1:0] = 7'd1;
            default: cnt[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 8));
        endcase
        apply_setting(pick_word(), pick_word(), pick_word(), pick_word(), cnt);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        amp_x         = '0;
        amp_y         = '0;
        amp_z         = '0;
        freq_x        = '0;
        freq_y        = '0;
        freq_z        = '0;
        out_ready     = 1'b0;
        hold_cycles   = 0;
        requests_sent = 0;
        settings_used = 0;
        set_idle_mode(IDLE_NONE);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: full amplitude, then all-zero amplitude at top speed
        offer_request('1, '1, '1, 16'h1000, 16'h2000, 16'h0000);
        offer_request('0, '0, '0, '1, '1, '1);
        close_burst();
        drain();

        // Largest step, start phases on the quadrant edges
        set_idle_mode(IDLE_BOTH);
        apply_setting('1, '1, 16'h4000, 16'h8000, 16'd5);
        offer_request('1, '0, 16'h8000, '1, '0, 16'h0001);
        offer_request(16'h8000, '1, 16'h0001, 16'h0800, '1, 16'h7FFF);
        close_burst();
        drain();

        // Zero step keeps each axis on its start phase
        apply_setting('0, 16'hC000, 16'h3FFF, 16'h7FFF, 16'd3);
        offer_request('1, '1, '1, pick_word(), pick_word(), pick_word());
        close_burst();
        drain();

        // Zero count, written with the upper data bits set: no points at all
        apply_setting(16'd655, '0, '0, '0, 16'hFF80);
        offer_random_request();
        offer_random_request();
        close_burst();
        drain();

        // Count above the limit clamps; spare indexes must change nothing
        apply_setting(16'h0123, 16'h1111, 16'h2222, 16'h3333, 16'd100);
        @(negedge clk);
        reg_write(CFG_SPARE_A, '1);
        reg_write(CFG_SPARE_B, 16'h5A5A);
        reg_write(CFG_SPARE_C, '1);
        reg_release();
        offer_random_request();
        offer_random_request();
        close_burst();
        drain();

        // Wide count write keeps only the low seven bits
        apply_setting(pick_word(), pick_word(), pick_word(), pick_word(), 16'hAB83);
        offer_random_request();
        offer_random_request();
        close_burst();
        drain();

        // Single point: first item is also the last
        set_idle_mode(IDLE_NONE);
        apply_setting(pick_word(), pick_word(), pick_word(), pick_word(), 16'd1);
        offer_random_request();
        offer_random_request();
        offer_random_request();
        close_burst();
        drain();

        // Largest count field value
        apply_setting(pick_word(), pick_word(), pick_word(), pick_word(), 16'h007F);
        offer_random_request();
        close_burst();
        drain();

        // Random phases, each with a fresh setting and idle pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == PRESSURE_PHASE)
            begin
                // Full curves while the output is held off: input must back up
                apply_setting(pick_word(), pick_word(), pick_word(), pick_word(),
                              DATA_W'(DEF_POINT_LIMIT));
                set_idle_mode(IDLE_NONE);
                @(posedge clk);
                hold_cycles = HOLD_OFF_CYCLES;
                @(negedge clk);
            end
            else
            begin
                apply_random_setting();
                set_idle_mode(idle_mode_t'(phase % 4));
            end
            repeat (PHASE_ITEMS) offer_random_request();
            close_burst();
            drain();
        end

        $display("summary: %0d requests under %0d register settings, %0d points checked",
                 requests_sent, settings_used, points_checked);
        $display("summary: zero, single, full and clamped counts, spare indexes, idle/stall mixes, %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatching points", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_controller.sv
rtl/lpg_datapath.sv
rtl/lissajous_point_generator_unit.sv
rtl/lpg_checker.sv
tb/lissajous_point_checker.sv
tb/tb_top.sv
